>>> design/refcounted_page_free_list_macros.svh
// assertion macros shared by the checker
`ifndef REFCOUNTED_PAGE_FREE_LIST_MACROS_SVH
`define REFCOUNTED_PAGE_FREE_LIST_MACROS_SVH

// same-cycle implication, disabled in reset
`define RPFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RPFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rpfl_pkg.sv
`timescale 1ns / 1ps
package rpfl_pkg;

  localparam int PAGE_W       = 10;
  localparam int TOP_W        = 11;
  localparam int CNT_W        = 8;
  localparam int LINK_W       = 11;
  localparam int LINK_END_BIT = 10;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  // func codes
  localparam logic [2:0] FUNC_ALLOC = 3'd0;
  localparam logic [2:0] FUNC_FREE  = 3'd1;
  localparam logic [2:0] FUNC_INC   = 3'd2;
  localparam logic [2:0] FUNC_DEC   = 3'd3;
  localparam logic [2:0] FUNC_QUERY = 3'd4;

  // status codes
  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_EMPTY = 3'd1;
  localparam logic [2:0] STAT_RANGE = 3'd2;
  localparam logic [2:0] STAT_SAT   = 3'd3;
  localparam logic [2:0] STAT_UNDER = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNTING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_PAGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_PAGE = 2'd2;

  localparam logic [LINK_W-1:0] LINK_END = 11'h400;

  typedef struct packed {
    logic [2:0]        func;
    logic [PAGE_W-1:0] page_number;
  } rpfl_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [PAGE_W-1:0] granted_page;
    logic [CNT_W-1:0]  count;
    logic              returned_to_list;
  } rpfl_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } rpfl_state_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic commit;
  } rpfl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } rpfl_sts_t;

endpackage

>>> design/refcounted_page_free_list.sv
`timescale 1ns / 1ps
// channel  direction  payload                                     transfer when
// in       input      func, page_number                           in_valid & in_ready
// out      output     status, granted_page, count, returned       out_valid & out_ready
// cfg      input      cfg_index, cfg_wdata                        cfg_we
//
// an operation runs as an accept step and a commit step: the accept step reads the count and link tables,
// the commit step does the count write-back, link push and head update
// (one read-modify-write of the count table per item)
// after reset a clearing pass zeroes all min(NUM_PAGES, 1024) entries of the count table,
// during which no item is accepted; configuration writes are taken at any time
// a result waits in the output register; the next item is accepted meanwhile and
// holds in its commit step until the output register frees up
module refcounted_page_free_list #(
  parameter int unsigned NUM_PAGES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // item input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rpfl_pkg::rpfl_in_t               in_data,
  // result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output rpfl_pkg::rpfl_out_t              out_data,
  // register writes
  input  logic                             cfg_we,
  input  logic [rpfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rpfl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // commands from the controller, status back from the datapath
  rpfl_pkg::rpfl_cmd_t cmd;
  rpfl_pkg::rpfl_sts_t sts;

  // sequencer: clear sweep, accept, commit
  rpfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tables, list head, config registers and result register
  rpfl_datapath #(
    .NUM_PAGES (NUM_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

>>> design/rpfl_ctrl.sv
`timescale 1ns / 1ps
module rpfl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rpfl_pkg::rpfl_sts_t sts,
  output rpfl_pkg::rpfl_cmd_t cmd
);

  rpfl_pkg::rpfl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpfl_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      rpfl_pkg::ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_nxt = rpfl_pkg::ST_IDLE;
      end
      rpfl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = rpfl_pkg::ST_EXEC;
        end
      end
      rpfl_pkg::ST_EXEC: begin
        // wait here until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = rpfl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rpfl_pkg::ST_CLEAR;
    endcase
    out_valid_nxt = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/rpfl_datapath.sv
`timescale 1ns / 1ps
module rpfl_datapath #(
  parameter int unsigned NUM_PAGES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rpfl_pkg::rpfl_cmd_t                 cmd,
  output rpfl_pkg::rpfl_sts_t                 sts,
  input  rpfl_pkg::rpfl_in_t                  in_data,
  output rpfl_pkg::rpfl_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [rpfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rpfl_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // page numbers are 10 bits, so no more than 1024 entries are reachable
  localparam int unsigned DEPTH = (NUM_PAGES < 1024) ? NUM_PAGES : 1024;
  localparam int AW = $clog2(DEPTH);

  // configuration
  logic                        counting_r;
  logic [rpfl_pkg::PAGE_W-1:0] low_page_r;
  logic [rpfl_pkg::TOP_W-1:0]  top_page_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counting_r <= 1'b0;
      low_page_r <= '0;
      top_page_r <= rpfl_pkg::TOP_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpfl_pkg::REG_COUNTING: counting_r <= cfg_wdata[0];
        rpfl_pkg::REG_LOW_PAGE: low_page_r <= cfg_wdata[rpfl_pkg::PAGE_W-1:0];
        rpfl_pkg::REG_TOP_PAGE: top_page_r <= cfg_wdata[rpfl_pkg::TOP_W-1:0];
        default: ;
      endcase
    end
  end

  // list head
  logic [rpfl_pkg::PAGE_W-1:0] head_r, head_nxt;
  logic                        empty_r, empty_nxt;

  // clear sweep over the count table
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      empty_r   <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      if (cmd.commit) begin
        head_r  <= head_nxt;
        empty_r <= empty_nxt;
      end
      if (cmd.clear_step) clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  assign sts.clear_last = (clr_cnt_r == AW'(DEPTH - 1));

  // latched item and table read data
  logic [2:0]                  func_r;
  logic [rpfl_pkg::PAGE_W-1:0] page_r;
  logic [rpfl_pkg::CNT_W-1:0]  cnt_rd_r;
  logic [rpfl_pkg::LINK_W-1:0] link_rd_r;

  logic [rpfl_pkg::CNT_W-1:0]  cnt_mem  [DEPTH];
  logic [rpfl_pkg::LINK_W-1:0] link_mem [DEPTH];

  logic [AW-1:0]               cnt_raddr, cnt_waddr;
  logic                        cnt_we;
  logic [rpfl_pkg::CNT_W-1:0]  cnt_wdata;
  logic                        push;
  logic [rpfl_pkg::LINK_W-1:0] link_wdata;
  rpfl_pkg::rpfl_out_t         res;
  rpfl_pkg::rpfl_out_t         out_r;

  assign cnt_raddr = (in_data.func == rpfl_pkg::FUNC_ALLOC) ? head_r[AW-1:0]
                                                            : in_data.page_number[AW-1:0];
  assign cnt_waddr = (func_r == rpfl_pkg::FUNC_ALLOC) ? head_r[AW-1:0] : page_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r   <= in_data.func;
      page_r   <= in_data.page_number;
      cnt_rd_r <= cnt_mem[cnt_raddr];
    end
    if (cmd.clear_step) begin
      cnt_mem[clr_cnt_r] <= '0;
    end else if (cmd.commit && cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) link_rd_r <= link_mem[head_r[AW-1:0]];
    if (cmd.commit && push) link_mem[page_r[AW-1:0]] <= link_wdata;
  end

  logic in_table, in_range;

  assign in_table = (32'(page_r) < NUM_PAGES);
  assign in_range = in_table && (page_r >= low_page_r) && ({1'b0, page_r} < top_page_r);
  assign link_wdata = empty_r ? rpfl_pkg::LINK_END : {1'b0, head_r};

  always_comb begin
    res       = '0;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_rd_r;
    push      = 1'b0;
    head_nxt  = head_r;
    empty_nxt = empty_r;
    unique case (func_r)
      rpfl_pkg::FUNC_ALLOC: begin
        if (empty_r) begin
          res.status = rpfl_pkg::STAT_EMPTY;
        end else begin
          if (cnt_rd_r == rpfl_pkg::CNT_MAX) begin
            res.status = rpfl_pkg::STAT_SAT;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rd_r + 8'd1;
          end
          res.count        = cnt_wdata;
          res.granted_page = head_r;
          if (link_rd_r[rpfl_pkg::LINK_END_BIT]) begin
            empty_nxt = 1'b1;
            head_nxt  = '0;
          end else begin
            head_nxt = link_rd_r[rpfl_pkg::PAGE_W-1:0];
          end
        end
      end
      rpfl_pkg::FUNC_FREE: begin
        if (!in_range) begin
          res.status = rpfl_pkg::STAT_RANGE;
        end else if (counting_r) begin
          if (cnt_rd_r == '0) begin
            res.status = rpfl_pkg::STAT_UNDER;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rd_r - 8'd1;
            res.count = cnt_wdata;
            push      = (cnt_wdata == '0);
          end
        end else begin
          push      = 1'b1;
          res.count = cnt_rd_r;
        end
        if (push) begin
          head_nxt             = page_r;
          empty_nxt            = 1'b0;
          res.returned_to_list = 1'b1;
        end
      end
      rpfl_pkg::FUNC_INC: begin
        if (!in_table) begin
          res.status = rpfl_pkg::STAT_RANGE;
        end else begin
          if (cnt_rd_r == rpfl_pkg::CNT_MAX) begin
            res.status = rpfl_pkg::STAT_SAT;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rd_r + 8'd1;
          end
          res.count = cnt_wdata;
        end
      end
      rpfl_pkg::FUNC_DEC: begin
        if (!in_table) begin
          res.status = rpfl_pkg::STAT_RANGE;
        end else begin
          if (cnt_rd_r == '0) begin
            res.status = rpfl_pkg::STAT_UNDER;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rd_r - 8'd1;
          end
          res.count = cnt_wdata;
        end
      end
      rpfl_pkg::FUNC_QUERY: begin
        if (!in_table) res.status = rpfl_pkg::STAT_RANGE;
        else res.count = cnt_rd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_r <= res;
  end

  assign out_data = out_r;

endmodule

>>> design/rpfl_checker.sv
`timescale 1ns / 1ps
`include "refcounted_page_free_list_macros.svh"
module rpfl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input rpfl_pkg::rpfl_out_t out_data
);

  `RPFL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_data), "result changed while stalled")
  `RPFL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
                    "input ready right after a transfer")
  `RPFL_ASSERT_NOW(a_empty_clean, out_valid && out_data.status == rpfl_pkg::STAT_EMPTY,
                   out_data.granted_page == '0 && out_data.count == '0 &&
                   !out_data.returned_to_list, "empty result carries data")
  `RPFL_ASSERT_NOW(a_range_clean, out_valid && out_data.status == rpfl_pkg::STAT_RANGE,
                   out_data.count == '0 && !out_data.returned_to_list, "range error with data")
  `RPFL_ASSERT_NOW(a_return_ok, out_valid && out_data.returned_to_list,
                   out_data.status == rpfl_pkg::STAT_OK && out_data.granted_page == '0,
                   "page return with bad status")

endmodule

bind refcounted_page_free_list rpfl_checker u_rpfl_checker (.*);

>>> tb/page_free_list_checker.sv
`timescale 1ns / 1ps
module page_free_list_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  rpfl_pkg::rpfl_in_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  rpfl_pkg::rpfl_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [rpfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rpfl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending_results
);
  import rpfl_pkg::*;

  localparam int PAGE_COUNT   = 1024;
  localparam int REPORT_LIMIT = 10;

  // shadow of the allocator
  logic              counting_on;
  logic [PAGE_W-1:0] low_lim;
  logic [TOP_W-1:0]  top_lim;
  logic [PAGE_W-1:0] head_page;
  logic              list_is_empty;
  logic [LINK_W-1:0] next_link_tbl [PAGE_COUNT];
  logic [CNT_W-1:0]  page_refs [PAGE_COUNT];

  rpfl_out_t predicted_results [$];
  int        errors = 0;

  function automatic void push_free_page(input logic [PAGE_W-1:0] pg);
    next_link_tbl[pg] = list_is_empty ? LINK_END : {1'b0, head_page};
    head_page         = pg;
    list_is_empty     = 1'b0;
  endfunction

  // a 10-bit page always lies inside the 1024-entry tables
  function automatic rpfl_out_t apply_page_op(input rpfl_in_t op);
    rpfl_out_t         r;
    logic [LINK_W-1:0] link;
    logic [PAGE_W-1:0] pg;
    r  = '0;
    pg = op.page_number;
    case (op.func)
      FUNC_ALLOC: begin
        if (list_is_empty) begin
          r.status = STAT_EMPTY;
        end else begin
          link = next_link_tbl[head_page];
          if (page_refs[head_page] == CNT_MAX) begin
            r.status = STAT_SAT;
          end else begin
            page_refs[head_page] = page_refs[head_page] + 1'b1;
          end
          r.count        = page_refs[head_page];
          r.granted_page = head_page;
          if (link[LINK_END_BIT]) begin
            list_is_empty = 1'b1;
            head_page     = '0;
          end else begin
            head_page = link[PAGE_W-1:0];
          end
        end
      end
      FUNC_FREE: begin
        if (pg < low_lim || {1'b0, pg} >= top_lim) begin
          r.status = STAT_RANGE;
        end else if (counting_on) begin
          if (page_refs[pg] == '0) begin
            r.status = STAT_UNDER;
          end else begin
            page_refs[pg] = page_refs[pg] - 1'b1;
            r.count       = page_refs[pg];
            if (page_refs[pg] == '0) begin
              push_free_page(pg);
              r.returned_to_list = 1'b1;
            end
          end
        end else begin
          push_free_page(pg);
          r.count            = page_refs[pg];
          r.returned_to_list = 1'b1;
        end
      end
      FUNC_INC: begin
        if (page_refs[pg] == CNT_MAX) r.status = STAT_SAT;
        else page_refs[pg] = page_refs[pg] + 1'b1;
        r.count = page_refs[pg];
      end
      FUNC_DEC: begin
        if (page_refs[pg] == '0) r.status = STAT_UNDER;
        else page_refs[pg] = page_refs[pg] - 1'b1;
        r.count = page_refs[pg];
      end
      FUNC_QUERY: begin
        r.count = page_refs[pg];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : track
    rpfl_out_t want;
    rpfl_out_t got;
    if (!rst_n) begin
      counting_on   = 1'b0;
      low_lim       = '0;
      top_lim       = 11'd1024;
      head_page     = '0;
      list_is_empty = 1'b1;
      for (int i = 0; i < PAGE_COUNT; i++) begin
        next_link_tbl[i] = '0;
        page_refs[i]     = '0;
      end
      predicted_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COUNTING: counting_on = cfg_wdata[0];
          REG_LOW_PAGE: low_lim     = cfg_wdata[PAGE_W-1:0];
          REG_TOP_PAGE: top_lim     = cfg_wdata[TOP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (predicted_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected result status %0d granted %0d count %0d returned %0d",
                     $time, got.status, got.granted_page, got.count, got.returned_to_list);
        end else begin
          want = predicted_results.pop_front();
          if (got.status !== want.status || got.granted_page !== want.granted_page ||
              got.count !== want.count || got.returned_to_list !== want.returned_to_list) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display({"%0t: mismatch (expected/actual) status %0d/%0d granted %0d/%0d",
                        " count %0d/%0d returned %0d/%0d"},
                       $time, want.status, got.status, want.granted_page, got.granted_page,
                       want.count, got.count, want.returned_to_list, got.returned_to_list);
          end
        end
      end
      if (in_valid && in_ready) predicted_results.push_back(apply_page_op(in_data));
    end
    fail_count      <= errors;
    pending_results <= predicted_results.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rpfl_pkg::*;

  // the limit covers the clearing pass after reset and the run itself
  localparam int CYCLE_LIMIT   = 400000;
  localparam int POOL_SPAN     = 24;
  localparam int SEGMENT_ITEMS = 300;

  // first func code the block ignores
  localparam logic [2:0] FUNC_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] FUNC_LAST_UNUSED  = 3'd7;

  // starts low without an edge at time zero
  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  rpfl_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  rpfl_out_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending_results;

  // idle odds in percent for each side, changed per phase
  int send_idle_pct;
  int recv_idle_pct;
  // items the block acts on (ignored funcs are not counted)
  int sent_items;
  int cycle_count;

  // current window of usable pages, steers page selection
  logic [PAGE_W-1:0] cur_low;
  logic [TOP_W-1:0]  cur_top;

  refcounted_page_free_list DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  page_free_list_checker page_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: stall at random, one decision per cycle
  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // hard stop in case a transfer never completes
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  // one transfer on the input channel; entered and left at a falling edge,
  // valid stays high on exit so back-to-back items need no extra assignment
  task automatic send_op(input logic [2:0] f, input logic [PAGE_W-1:0] pg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {f, pg};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (f <= FUNC_QUERY) sent_items++;
  endtask

  // hold off the sender until every result is back, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // registers only change while the block is idle
  task automatic set_config(input logic counting, input logic [PAGE_W-1:0] lo,
                            input logic [TOP_W-1:0] hi);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_COUNTING;
    cfg_wdata <= CFG_DATA_W'(counting);
    @(negedge clk);
    cfg_index <= REG_LOW_PAGE;
    cfg_wdata <= CFG_DATA_W'(lo);
    @(negedge clk);
    cfg_index <= REG_TOP_PAGE;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we  <= 1'b0;
    cur_low = lo;
    cur_top = hi;
  endtask

  // mostly a small pool just above low_page so pages get reused,
  // then the range edges, then anything
  function automatic logic [PAGE_W-1:0] pick_page();
    int roll;
    int v;
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      v = int'(cur_low) + int'($urandom_range(0, POOL_SPAN - 1));
      if (v > 1023) v = 1023;
    end else if (roll < 87) begin
      case ($urandom_range(0, 5))
        0:       v = int'(cur_low) - 1;
        1:       v = int'(cur_low);
        2:       v = int'(cur_top) - 1;
        3:       v = int'(cur_top);
        4:       v = 0;
        default: v = 1023;
      endcase
    end else begin
      v = int'($urandom_range(0, 1023));
    end
    return PAGE_W'(v);
  endfunction

  // drive a page's count up to 255 and beyond, push it back without counting and pop it again,
  // so both increment and allocate hit the saturated count
  task automatic saturate_page();
    logic [PAGE_W-1:0] pg;
    pg = cur_low + PAGE_W'($urandom_range(0, 7));
    repeat ($urandom_range(256, 262)) send_op(FUNC_INC, pg);
    send_op(FUNC_FREE, pg);
    send_op(FUNC_ALLOC, PAGE_W'($urandom_range(0, 1023)));
    send_op(FUNC_QUERY, pg);
  endtask

  // random sequences with some structure; one full drain somewhere in the middle
  task automatic random_traffic(input int quota);
    int                goal;
    int                pause_at;
    int                kind;
    int                len;
    int                k;
    logic [PAGE_W-1:0] pg;
    goal     = sent_items + quota;
    pause_at = sent_items + int'($urandom_range(quota / 4, 3 * quota / 4));
    while (sent_items < goal) begin
      if (pause_at >= 0 && sent_items >= pause_at) begin
        drain_results();
        pause_at = -1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // churn: mostly allocate and free traffic on the pool, with some increment, decrement, query and ignored funcs
        len = $urandom_range(4, 12);
        repeat (len) begin
          k = $urandom_range(0, 99);
          if (k < 35)      send_op(FUNC_ALLOC, PAGE_W'($urandom_range(0, 1023)));
          else if (k < 70) send_op(FUNC_FREE, pick_page());
          else if (k < 78) send_op(FUNC_INC, pick_page());
          else if (k < 86) send_op(FUNC_DEC, pick_page());
          else if (k < 94) send_op(FUNC_QUERY, pick_page());
          else send_op(3'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED)), pick_page());
        end
      end else if (kind < 70) begin
        // refill the list, then draw from it
        repeat ($urandom_range(3, 10)) send_op(FUNC_FREE, pick_page());
        repeat ($urandom_range(1, 6)) send_op(FUNC_ALLOC, PAGE_W'($urandom_range(0, 1023)));
      end else if (kind < 85) begin
        // count walk: up k, down k+1 hits underflow when it started at zero
        pg  = pick_page();
        len = $urandom_range(1, 6);
        repeat (len) send_op(FUNC_INC, pg);
        repeat (len + 1) send_op(FUNC_DEC, pg);
        send_op(FUNC_QUERY, pg);
      end else begin
        // noise: any func, any page
        repeat ($urandom_range(1, 4))
          send_op(3'($urandom_range(0, 7)), PAGE_W'($urandom_range(0, 1023)));
      end
    end
  endtask

  initial begin : stimulus
    logic [PAGE_W-1:0] seg_low;
    logic [TOP_W-1:0]  seg_top;

    // every input known from time zero
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    sent_items    = 0;
    cur_low       = '0;
    cur_top       = 11'd1024;
    send_idle_pct = 6;
    recv_idle_pct = 72;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: initial fill with a narrow window 16..31
    set_config(1'b0, 10'd16, 11'd32);
    send_op(FUNC_ALLOC, 10'd0);           // empty list
    send_op(FUNC_FREE, 10'd15);           // just below low_page
    send_op(FUNC_FREE, 10'd32);           // at top_page
    send_op(FUNC_FREE, 10'd16);           // first push ends the list
    send_op(FUNC_FREE, 10'd31);
    send_op(FUNC_FREE, 10'd20);
    send_op(FUNC_INC, 10'd1023);
    send_op(FUNC_DEC, 10'd1023);
    send_op(FUNC_DEC, 10'd1023);          // underflow on decrement
    send_op(FUNC_QUERY, 10'd0);
    send_op(FUNC_FIRST_UNUSED, 10'd1023); // ignored funcs
    send_op(FUNC_FIRST_UNUSED + 3'd1, 10'd0);
    send_op(FUNC_LAST_UNUSED, 10'h2a5);
    send_op(FUNC_ALLOC, 10'h3ff);         // pops 20, 31, 16 in that order
    send_op(FUNC_ALLOC, 10'd0);
    send_op(FUNC_ALLOC, 10'd0);
    send_op(FUNC_ALLOC, 10'd0);           // drained again

    // directed: counting on
    set_config(1'b1, 10'd16, 11'd32);
    send_op(FUNC_FREE, 10'd20);           // count reaches zero, pushed
    send_op(FUNC_FREE, 10'd20);           // free at zero count
    send_op(FUNC_INC, 10'd31);
    send_op(FUNC_FREE, 10'd31);           // count stays above zero, not pushed
    send_op(FUNC_ALLOC, 10'd0);
    send_op(FUNC_FREE, 10'd0);            // below low_page
    send_op(FUNC_QUERY, 10'd31);

    // random, sender mostly busy, receiver mostly stalled
    set_config(1'b0, 10'd0, 11'd1024);
    saturate_page();
    random_traffic(SEGMENT_ITEMS);
    seg_low = PAGE_W'($urandom_range(0, 500));
    seg_top = TOP_W'($urandom_range(int'(seg_low) + 1, 1024));
    set_config(1'b1, seg_low, seg_top);
    random_traffic(SEGMENT_ITEMS);

    // random, sender mostly idle, receiver mostly ready
    send_idle_pct = 72;
    recv_idle_pct = 6;
    set_config(1'b0, 10'd1000, 11'd1024);
    saturate_page();
    random_traffic(SEGMENT_ITEMS);
    set_config(1'b1, 10'd1023, 11'd1024); // a single usable page
    random_traffic(SEGMENT_ITEMS);

    // random, full throughput on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(1'b1, 10'd600, 11'd0);     // empty window, every free rejected
    random_traffic(SEGMENT_ITEMS);
    set_config(1'b1, 10'd0, 11'd1024);
    random_traffic(SEGMENT_ITEMS);

    // let the last results out, then wait for anything stray
    drain_results();
    repeat (16) @(negedge clk);

    if (fail_count == 0 && pending_results == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
